FILE: hw/rtl/ic_pkg.sv
package ic_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_ATTRIBUTES       = 64;
  localparam int DEFAULT_MAX_IMPLICATIONS = 256;

  // Fixed field widths of the stream beats and the configuration register.
  localparam int SET_W   = 64;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  // Bit positions of the input fields inside in_tdata.
  localparam int IDX_LSB   = 0;
  localparam int PREM_LSB  = IDX_LSB + INDEX_W;
  localparam int CONC_LSB  = PREM_LSB + SET_W;
  localparam int QUERY_LSB = CONC_LSB + SET_W;
  localparam int IN_DATA_W = QUERY_LSB + SET_W;

  // Command codes carried in in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Closure sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ic_state_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;       // ready for a new beat
    logic res_valid;  // closed set waits for the output register
  } ic_status_t;

endpackage

FILE: hw/rtl/ic_ram.sv
module ic_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ic_engine.sv
module ic_engine
  import ic_pkg::*;
#(
  parameter int ATTRIBUTES       = DEFAULT_ATTRIBUTES,
  parameter int MAX_IMPLICATIONS = DEFAULT_MAX_IMPLICATIONS,
  localparam int ADDR_W = (MAX_IMPLICATIONS > 1) ? $clog2(MAX_IMPLICATIONS) : 1,
  localparam int CNT_W  = $clog2(MAX_IMPLICATIONS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ATTRIBUTES-1:0]   query,
  input  logic [CNT_W-1:0]        count,
  input  logic [2*ATTRIBUTES-1:0] rd_data,
  input  logic                    res_take,
  output logic                    rd_en,
  output logic [ADDR_W-1:0]       rd_addr,
  output ic_status_t              status,
  output logic [ATTRIBUTES-1:0]   result
);

  ic_state_t             state_r, state_nxt;
  logic [ATTRIBUTES-1:0] set_r, set_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic                  chg_r, chg_nxt;

  logic [ATTRIBUTES-1:0] prem, conc, upd;
  logic                  hit, chg, pass_chg, issue;

  // Evaluate the entry whose read data returns this cycle against the current set.
  assign prem     = rd_data[ATTRIBUTES-1:0];
  assign conc     = rd_data[2*ATTRIBUTES-1:ATTRIBUTES];
  assign hit      = ((prem & ~set_r) == '0);
  assign upd      = hit ? (set_r | conc) : set_r;
  assign chg      = (upd != set_r);
  assign pass_chg = chg_r | chg;
  assign issue    = (rd_idx_r < count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (count == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && rd_last_r && !pass_chg) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    status.idle      = (state_r == ST_IDLE);
    status.res_valid = (state_r == ST_DONE);
    rd_en            = (state_r == ST_SCAN) && issue;
    rd_addr          = rd_idx_r[ADDR_W-1:0];
    result           = set_r;
  end

  // Scan datapath: one table read issued per cycle, a new pass while the set grows.
  always_comb begin
    set_nxt     = set_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    chg_nxt     = chg_r;
    if (state_r == ST_IDLE) begin
      if (start) begin
        set_nxt    = query;
        count_nxt  = count;
        rd_idx_nxt = '0;
        chg_nxt    = 1'b0;
      end
    end else if (state_r == ST_SCAN) begin
      if (issue) begin
        rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        rd_vld_nxt  = 1'b1;
        rd_last_nxt = (rd_idx_r == count_r - CNT_W'(1));
      end
      if (rd_vld_r) begin
        set_nxt = upd;
        chg_nxt = pass_chg;
        if (rd_last_r && pass_chg) begin
          rd_idx_nxt = '0;
          chg_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      chg_r     <= 1'b0;
      count_r   <= '0;
      set_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      chg_r     <= chg_nxt;
      count_r   <= count_nxt;
      set_r     <= set_nxt;
    end
  end

endmodule

FILE: hw/rtl/implication_closure.sv
// Closure of an attribute set under a table of implications. A write beat (tuser 0) stores
// a premise and a conclusion at entry_index and returns nothing. A query beat (tuser 1)
// starts from query_set and sweeps entries 0 to active_implications-1, one table RAM read
// per cycle; each entry whose premise lies inside the current set adds its conclusion.
// Sweeps repeat until one adds nothing, then the closed set is returned. With N active
// entries a query needs at most N+1 sweeps of the table RAM, which has a single read port.
// The input is ready again once a result has moved to the output register, so writes
// may go on while a result waits to be taken. The user must write active_implications
// only while the block is idle; the block itself does not enforce it.
module implication_closure
  import ic_pkg::*;
#(
  parameter int ATTRIBUTES       = DEFAULT_ATTRIBUTES,
  parameter int MAX_IMPLICATIONS = DEFAULT_MAX_IMPLICATIONS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index[7:0], premise_bits[71:8], conclusion_bits[135:72], query_set[199:136]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // command[0]
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // closed_set[63:0]
  output logic [SET_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam int ADDR_W = (MAX_IMPLICATIONS > 1) ? $clog2(MAX_IMPLICATIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_IMPLICATIONS + 1);

  logic [COUNT_W-1:0]      active_r;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [SET_W-1:0]        out_tdata_r, out_tdata_nxt;

  logic                    in_acc, ram_we, res_take;
  logic [ADDR_W-1:0]       ram_waddr, rd_addr;
  logic [2*ATTRIBUTES-1:0] ram_wdata, rd_data;
  logic                    rd_en;
  logic [CNT_W-1:0]        count;
  logic [ATTRIBUTES-1:0]   query, result;
  ic_status_t              status;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end

  // Active count, saturated to the table depth.
  assign count = (32'(active_r) > MAX_IMPLICATIONS) ? CNT_W'(MAX_IMPLICATIONS)
                                                    : CNT_W'(active_r);

  // Input beat decode; writes past the table depth are dropped.
  assign in_tready = status.idle;
  assign in_acc    = in_tvalid && in_tready;
  assign ram_we    = in_acc && (in_tuser == CMD_WRITE)
                     && (32'(in_tdata[IDX_LSB +: INDEX_W]) < MAX_IMPLICATIONS);
  assign ram_waddr = ADDR_W'(in_tdata[IDX_LSB +: INDEX_W]);
  assign ram_wdata = {in_tdata[CONC_LSB +: ATTRIBUTES], in_tdata[PREM_LSB +: ATTRIBUTES]};
  assign query     = in_tdata[QUERY_LSB +: ATTRIBUTES];

  ic_ram #(
    .WIDTH (2*ATTRIBUTES),
    .DEPTH (MAX_IMPLICATIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ic_engine #(
    .ATTRIBUTES       (ATTRIBUTES),
    .MAX_IMPLICATIONS (MAX_IMPLICATIONS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && (in_tuser == CMD_QUERY)),
    .query    (query),
    .count    (count),
    .rd_data  (rd_data),
    .res_take (res_take),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .status   (status),
    .result   (result)
  );

  // Output register: loads a finished closure whenever it is empty or being drained.
  assign res_take = status.res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_take) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = SET_W'(result);
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A table write never coincides with a closure sweep read.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && rd_en))
    else $error("table written during a closure sweep");

  // Sweep reads stay below the table depth.
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (32'(rd_addr) < MAX_IMPLICATIONS))
    else $error("table read out of range");

  // A result only appears in the output register after the sequencer handed one over.
  a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(res_take))
    else $error("output valid without a finished closure");

  // The output register is empty after reset.
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid_r)
    else $error("output valid right after reset");

endmodule

FILE: tb/sv/closure_checker.sv
// Watches the three channels of implication_closure, predicts the closed set of every
// query beat from its own copy of the implication table and the active count, and
// compares each result beat with the oldest prediction.
module closure_checker
  import ic_pkg::*;
#(
  parameter int ATTRIBUTES       = DEFAULT_ATTRIBUTES,
  parameter int MAX_IMPLICATIONS = DEFAULT_MAX_IMPLICATIONS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [SET_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [COUNT_W-1:0]   cfg_data,
  output int unsigned          mismatch_count,
  output int unsigned          closures_pending
);

  localparam logic [SET_W-1:0] ATTR_MASK = {SET_W{1'b1}} >> (SET_W - ATTRIBUTES);

  // Shadow copy of the implication table and the active count register.
  logic [SET_W-1:0]   premise_mem    [MAX_IMPLICATIONS];
  logic [SET_W-1:0]   conclusion_mem [MAX_IMPLICATIONS];
  logic [COUNT_W-1:0] active_count;
  logic [SET_W-1:0]   expected_closures [$];
  int unsigned        errors_seen;

  // Naive closure: sweep the active entries until a sweep adds nothing. Each entry
  // may fire at most once per query.
  function automatic logic [SET_W-1:0] predict_closure(input logic [SET_W-1:0] start);
    logic [SET_W-1:0] grown;
    logic [SET_W-1:0] last;
    bit               fired [MAX_IMPLICATIONS];
    int               span;
    int               i;
    span = (int'(active_count) > MAX_IMPLICATIONS) ? MAX_IMPLICATIONS : int'(active_count);
    for (i = 0; i < MAX_IMPLICATIONS; i++) begin
      fired[i] = 1'b0;
    end
    grown = start & ATTR_MASK;
    do begin
      last = grown;
      for (i = 0; i < span; i++) begin
        if (!fired[i] && ((premise_mem[i] & ~grown) == '0)) begin
          grown    = grown | conclusion_mem[i];
          fired[i] = 1'b1;
        end
      end
    end while (grown != last);
    return grown & ATTR_MASK;
  endfunction

  // Result beats are checked before input beats are predicted, so a result and a new
  // query in the same cycle keep their order.
  always @(posedge clk) begin : watch
    logic [SET_W-1:0] want;
    int               slot;
    if (!rst_n) begin
      active_count = '0;
      expected_closures.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_closures.size() == 0) begin
          $error("closed_set beat with no expected value: actual %h", out_tdata);
          errors_seen++;
        end else begin
          want = expected_closures.pop_front();
          if (out_tdata !== want) begin
            $error("closed_set mismatch: expected %h, actual %h", want, out_tdata);
            errors_seen++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_WRITE) begin
          slot = int'(in_tdata[IDX_LSB +: INDEX_W]);
          if (slot < MAX_IMPLICATIONS) begin
            premise_mem[slot]    = in_tdata[PREM_LSB +: SET_W] & ATTR_MASK;
            conclusion_mem[slot] = in_tdata[CONC_LSB +: SET_W] & ATTR_MASK;
          end
        end else begin
          want = predict_closure(in_tdata[QUERY_LSB +: SET_W]);
          expected_closures.insert(expected_closures.size(), want);
        end
      end
      // The register takes a new count at the end of the cycle.
      if (cfg_valid && cfg_ready) begin
        active_count = cfg_data;
      end
    end
    mismatch_count   <= errors_seen;
    closures_pending <= expected_closures.size();
  end

endmodule

FILE: tb/sv/implication_closure_tb.sv
module implication_closure_tb;
  import ic_pkg::*;

  localparam int ITEM_TARGET = 580;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int TABLE_DEPTH = DEFAULT_MAX_IMPLICATIONS;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [SET_W-1:0]     out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data;
  int unsigned          mismatch_count;
  int unsigned          closures_pending;

  // Stimulus bookkeeping.
  bit entry_written [TABLE_DEPTH];
  int items_sent = 0;
  int cycle_count = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit hold_req = 1'b0;
  int uni_lo = 0;
  int uni_span = SET_W;

  always #5 clk = ~clk;

  implication_closure u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  closure_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .closures_pending (closures_pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Attribute sets are mostly a few bits from the phase's band of attributes, so that
  // premises often match and closures run over several sweeps.
  function automatic logic [SET_W-1:0] draw_set(input int min_bits, input int max_bits);
    logic [SET_W-1:0] bits;
    int               count;
    int               k;
    bits = '0;
    case ($urandom_range(0, 15))
      0: bits = '0;
      1: bits = '1;
      2: bits = {$urandom, $urandom};
      default: begin
        count = $urandom_range(min_bits, max_bits);
        for (k = 0; k < count; k++) begin
          bits[uni_lo + $urandom_range(0, uni_span - 1)] = 1'b1;
        end
      end
    endcase
    return bits;
  endfunction

  // Offer one input beat after a random gap and hold it until it is taken.
  task automatic offer_beat(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input logic [SET_W-1:0] prem, input logic [SET_W-1:0] conc,
                            input logic [SET_W-1:0] qset);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {qset, conc, prem, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
  endtask

  task automatic write_entry(input int idx, input logic [SET_W-1:0] prem,
                             input logic [SET_W-1:0] conc);
    offer_beat(CMD_WRITE, INDEX_W'(idx), prem, conc, {$urandom, $urandom});
    entry_written[idx] = 1'b1;
  endtask

  // The write fields of a query beat carry noise.
  task automatic ask_closure(input logic [SET_W-1:0] qset);
    offer_beat(CMD_QUERY, INDEX_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
               qset);
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Wait for every predicted closure, then let trailing write beats settle.
  task automatic drain_results();
    pause_input();
    while (closures_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Make sure every entry that becomes active holds a written value, then write the
  // register while the block is idle.
  task automatic set_active(input int n);
    int i;
    for (i = 0; i < ((n > TABLE_DEPTH) ? TABLE_DEPTH : n); i++) begin
      if (!entry_written[i]) begin
        write_entry(i, draw_set(1, 3), draw_set(1, 4));
      end
    end
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(n);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One phase: pick an active count and a band of attributes, then mix writes and
  // queries. A few early phases are fixed to reach the extremes and the stall cases.
  task automatic run_phase(input int phase);
    int n;
    int eff;
    int count;
    int k;
    int pick;
    case (phase)
      0: n = TABLE_DEPTH;
      1: n = 0;
      2: n = (1 << COUNT_W) - 1;
      3: n = 4;
      default: begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          n = $urandom_range(1, 16);
        end else if (pick <= 7) begin
          n = $urandom_range(17, 64);
        end else if (pick == 8) begin
          n = $urandom_range(65, TABLE_DEPTH - 1);
        end else begin
          n = ($urandom_range(0, 1) != 0) ? TABLE_DEPTH : 0;
        end
      end
    endcase
    eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    uni_span  = $urandom_range(4, SET_W);
    uni_lo    = $urandom_range(0, SET_W - uni_span);
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    set_active(n);
    count = (eff > 64) ? 8 : $urandom_range(10, 30);

    // The receiver holds off while queries keep coming, so the block backs up.
    if (phase == 3) begin
      in_burst = 1'b1;
      hold_req = 1'b1;
      repeat (12) ask_closure(draw_set(1, 6));
      in_burst = 1'b0;
    end

    for (k = 0; k < count; k++) begin
      // Halfway through one phase the sender waits until every closure is back.
      if (phase == 4 && k == count / 2) begin
        drain_results();
      end
      if ($urandom_range(0, 1) != 0) begin
        ask_closure(draw_set(1, 6));
      end else if (eff > 0 && $urandom_range(0, 3) != 0) begin
        write_entry($urandom_range(0, eff - 1), draw_set(1, 3), draw_set(1, 4));
      end else begin
        write_entry($urandom_range(0, TABLE_DEPTH - 1), draw_set(1, 3), draw_set(1, 4));
      end
    end
  endtask

  // Receiver: random stalls per beat, plus one long hold-off on request.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = out_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Sender: reset, directed beats, random phases, verdict.
  initial begin
    int k;
    int phase;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_WRITE;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With the reset count of zero a query comes back unchanged.
    ask_closure('1);
    ask_closure('0);

    // Entry 0 always fires, entry 1 only on the full set, and entries 2 to 9 form a
    // chain stored in reverse scan order, so it grows by one link per sweep.
    write_entry(0, '0, {1'b1, {(SET_W - 1){1'b0}}});
    write_entry(1, '1, SET_W'(1));
    for (k = 2; k <= 9; k++) begin
      write_entry(k, SET_W'(1) << (19 - k), SET_W'(1) << (20 - k));
    end
    write_entry(TABLE_DEPTH - 1, '1, '1);
    set_active(10);
    ask_closure(SET_W'(1) << 10);
    ask_closure('0);
    ask_closure('1);
    ask_closure(SET_W'(1) << 17);
    ask_closure({$urandom, $urandom});
    set_active(1);
    ask_closure(SET_W'(1) << 10);
    set_active(0);
    ask_closure({$urandom, $urandom});

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase);
      phase++;
    end

    drain_results();
    if (mismatch_count == 0 && closures_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ic_pkg.sv
hw/rtl/ic_ram.sv
hw/rtl/ic_engine.sv
hw/rtl/implication_closure.sv
tb/sv/closure_checker.sv
tb/sv/implication_closure_tb.sv
